FILE: hdl/fdpm_pkg.sv
// Shared types, constants and helper functions for the frontlight dual PWM duty mapper.
// Used by fdpm_engine and frontlight_dual_pwm_duty_mapper_core.
package fdpm_pkg;

    localparam int MAX_DUTY_BITS_DEF = 16;

    localparam logic [4:0] DUTY_BITS_RST    = 5'd10;
    localparam logic       ACTIVE_HIGH_RST  = 1'b1;
    localparam logic       DUAL_CHANNEL_RST = 1'b0;
    localparam logic [6:0] LAST_ON_RST      = 7'd100;
    localparam logic [7:0] PCT_LIMIT        = 8'd100;

    localparam logic [2:0] OP_SET_PCT   = 3'd0;
    localparam logic [2:0] OP_SET_LEVEL = 3'd1;
    localparam logic [2:0] OP_SET_WARM  = 3'd2;
    localparam logic [2:0] OP_OFF       = 3'd3;
    localparam logic [2:0] OP_ON        = 3'd4;

    localparam logic [1:0] CFG_DUTY_BITS    = 2'd0;
    localparam logic [1:0] CFG_ACTIVE_HIGH  = 2'd1;
    localparam logic [1:0] CFG_DUAL_CHANNEL = 2'd2;

    // Division by D = 2^S - K is done by folding the high part back in as high*K.
    localparam logic [31:0] DIV_PCT_D    = 32'd65535;
    localparam logic [15:0] DIV_PCT_K    = 16'd1;
    localparam logic [31:0] DIV_PCT_BIAS = 32'd32767;
    localparam logic [31:0] DIV_LVL_D    = 32'd64516;
    localparam logic [15:0] DIV_LVL_K    = 16'd1020;
    localparam logic [31:0] DIV_LVL_BIAS = 32'd0;
    localparam logic [31:0] DIV_WARM_D    = 32'd100;
    localparam logic [15:0] DIV_WARM_K    = 16'd28;
    localparam logic [31:0] DIV_WARM_BIAS = 32'd50;

    typedef enum logic [1:0] {
        DIV_PCT,
        DIV_LVL,
        DIV_WARM
    } div_kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SCALE,
        ST_GAMMA,
        ST_LOAD,
        ST_FOLD,
        ST_ACC,
        ST_FIX,
        ST_SPLIT,
        ST_DONE
    } eng_state_t;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] value;
    } in_item_t;

    typedef struct packed {
        logic [15:0] cool_pin_duty;
        logic [15:0] warm_pin_duty;
        logic        warm_driven;
        logic [15:0] total_duty;
        logic        lit;
    } out_item_t;

    typedef struct packed {
        logic       level_mode;
        logic [7:0] level;
        logic [6:0] percent;
        logic [6:0] share;
        logic [4:0] duty_bits;
        logic       active_high;
        logic       dual;
    } job_t;

    localparam logic [15:0] GAMMA_LUT [0:100] = '{
        16'd0,     16'd32,    16'd101,   16'd197,   16'd318,   16'd460,   16'd622,
        16'd803,   16'd1001,  16'd1217,  16'd1449,  16'd1697,  16'd1960,  16'd2237,
        16'd2529,  16'd2835,  16'd3155,  16'd3488,  16'd3834,  16'd4193,  16'd4565,
        16'd4949,  16'd5345,  16'd5753,  16'd6173,  16'd6604,  16'd7047,  16'd7502,
        16'd7967,  16'd8444,  16'd8931,  16'd9429,  16'd9938,  16'd10457, 16'd10987,
        16'd11527, 16'd12077, 16'd12638, 16'd13208, 16'd13789, 16'd14379, 16'd14979,
        16'd15588, 16'd16208, 16'd16836, 16'd17474, 16'd18122, 16'd18779, 16'd19445,
        16'd20120, 16'd20804, 16'd21497, 16'd22200, 16'd22911, 16'd23631, 16'd24360,
        16'd25097, 16'd25843, 16'd26598, 16'd27362, 16'd28134, 16'd28914, 16'd29703,
        16'd30500, 16'd31306, 16'd32120, 16'd32942, 16'd33772, 16'd34611, 16'd35457,
        16'd36312, 16'd37175, 16'd38045, 16'd38924, 16'd39811, 16'd40705, 16'd41608,
        16'd42518, 16'd43436, 16'd44361, 16'd45295, 16'd46236, 16'd47185, 16'd48141,
        16'd49105, 16'd50076, 16'd51055, 16'd52042, 16'd53036, 16'd54037, 16'd55046,
        16'd56062, 16'd57086, 16'd58117, 16'd59155, 16'd60200, 16'd61253, 16'd62313,
        16'd63380, 16'd64454, 16'd65535
    };

    function automatic logic [15:0] gamma_value(input logic [6:0] pct);
        logic [6:0] idx;
        idx = (pct > 7'(PCT_LIMIT)) ? 7'(PCT_LIMIT) : pct;
        return GAMMA_LUT[idx];
    endfunction

    function automatic logic [15:0] full_duty(input logic [4:0] bits, input int max_bits);
        logic [4:0] b;
        b = (bits == 5'd0) ? 5'd1 : bits;
        if (b > 5'(max_bits))
        begin
            b = 5'(max_bits);
        end
        return 16'((17'd1 << b) - 17'd1);
    endfunction

    // floor(p * 255 / 100) by reciprocal multiply, exact for p up to 100
    function automatic logic [7:0] level_of_pct(input logic [6:0] p);
        logic [14:0] x;
        logic [27:0] y;
        x = 15'(p) * 15'd255;
        y = 28'(x) * 28'd5243;
        return y[26:19];
    endfunction

    // floor(v * 100 / 255) by reciprocal multiply, exact for v up to 255
    function automatic logic [6:0] pct_of_level(input logic [7:0] v);
        logic [14:0] x;
        logic [31:0] y;
        x = 15'(v) * 15'd100;
        y = 32'(x) * 32'd65794;
        return y[30:24];
    endfunction

endpackage

FILE: hdl/frontlight_dual_pwm_duty_mapper_core.sv
// Top level of the frontlight dual PWM duty mapper: command handshake, brightness state,
// configuration registers and output register. Uses fdpm_pkg and fdpm_engine.
//
// Usage:
//   Input channel (in_valid / in_stall / in_item) takes one light command per item:
//   set percent, set level, set warm share, off, on. Each command yields exactly one
//   result item on the output channel (out_valid / out_stall / out_item) with the cool
//   and warm pin duties, the logical total duty and the lit flag.
//   Configuration port (cfg_valid / cfg_ready / cfg_index / cfg_data) writes duty_bits,
//   active_high and dual_channel; cfg_ready is always high. Write only while idle.
// Sequencing:
//   One command at a time. The time from acceptance to the output register is set
//   by the passes through the shared 16x16 multiplier: the curve multiply, the
//   constant-division folds of the total, and the folds of the warm split.
//   in_stall stays high from acceptance until the result enters the output register.
// Reset:
//   rst_n clears the brightness state (off, last on level 100 percent, no warm share)
//   and loads duty_bits 10, active high, single channel. No result is pending.
// Output stall:
//   A finished result waits in the output register; the next command is accepted
//   meanwhile and its result waits in the engine until the register frees.
module frontlight_dual_pwm_duty_mapper_core
#(
    parameter int MAX_DUTY_BITS = fdpm_pkg::MAX_DUTY_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  fdpm_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output fdpm_pkg::out_item_t out_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [4:0]          cfg_data
);

    import fdpm_pkg::*;

    logic       busy_reg, busy_next;
    logic       start_reg;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_item_reg;

    logic [4:0] duty_bits_reg;
    logic       active_high_reg;
    logic       dual_channel_reg;

    logic [6:0] percent_reg, percent_next;
    logic [7:0] level_reg, level_next;
    logic       level_mode_reg, level_mode_next;
    logic [6:0] last_on_reg, last_on_next;
    logic [6:0] share_reg, share_next;

    logic       accept;
    logic       res_ready;
    logic       eng_done;
    out_item_t  eng_result;
    job_t       job;
    logic [6:0] val_sat;
    logic [6:0] pct_cmd;
    logic       pct_write;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = busy_reg;
    assign res_ready = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;

    assign val_sat = (in_item.value > PCT_LIMIT) ? 7'(PCT_LIMIT) : in_item.value[6:0];

    always_comb
    begin
        percent_next    = percent_reg;
        level_next      = level_reg;
        level_mode_next = level_mode_reg;
        last_on_next    = last_on_reg;
        share_next      = share_reg;
        pct_write       = 1'b0;
        pct_cmd         = val_sat;
        if (accept)
        begin
            case (in_item.op)
                OP_SET_PCT:
                begin
                    pct_write = 1'b1;
                    pct_cmd   = val_sat;
                end
                OP_SET_LEVEL:
                begin
                    level_next      = in_item.value;
                    percent_next    = pct_of_level(in_item.value);
                    level_mode_next = 1'b1;
                end
                OP_SET_WARM:
                begin
                    share_next = val_sat;
                end
                OP_OFF:
                begin
                    pct_write = 1'b1;
                    pct_cmd   = 7'd0;
                end
                OP_ON:
                begin
                    pct_write = 1'b1;
                    pct_cmd   = last_on_reg;
                end
                default:
                begin
                    pct_write = 1'b0;
                end
            endcase
        end
        if (pct_write)
        begin
            percent_next    = pct_cmd;
            level_next      = level_of_pct(pct_cmd);
            level_mode_next = 1'b0;
            if (pct_cmd != 7'd0)
            begin
                last_on_next = pct_cmd;
            end
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (eng_done && res_ready)
        begin
            busy_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (eng_done && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b0;
            start_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
            duty_bits_reg    <= DUTY_BITS_RST;
            active_high_reg  <= ACTIVE_HIGH_RST;
            dual_channel_reg <= DUAL_CHANNEL_RST;
            percent_reg      <= 7'd0;
            level_reg        <= 8'd0;
            level_mode_reg   <= 1'b0;
            last_on_reg      <= LAST_ON_RST;
            share_reg        <= 7'd0;
        end
        else
        begin
            busy_reg       <= busy_next;
            start_reg      <= accept;
            out_valid_reg  <= out_valid_next;
            percent_reg    <= percent_next;
            level_reg      <= level_next;
            level_mode_reg <= level_mode_next;
            last_on_reg    <= last_on_next;
            share_reg      <= share_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_DUTY_BITS:    duty_bits_reg    <= cfg_data;
                    CFG_ACTIVE_HIGH:  active_high_reg  <= cfg_data[0];
                    CFG_DUAL_CHANNEL: dual_channel_reg <= cfg_data[0];
                    default:          duty_bits_reg    <= duty_bits_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (eng_done && res_ready)
        begin
            out_item_reg <= eng_result;
        end
    end

    always_comb
    begin
        job.level_mode  = level_mode_reg;
        job.level       = level_reg;
        job.percent     = percent_reg;
        job.share       = share_reg;
        job.duty_bits   = duty_bits_reg;
        job.active_high = active_high_reg;
        job.dual        = dual_channel_reg;
    end

    fdpm_engine
    #(
        .MAX_DUTY_BITS (MAX_DUTY_BITS)
    )
    u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start_reg),
        .job       (job),
        .res_ready (res_ready),
        .done      (eng_done),
        .result    (eng_result)
    );

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    a_lit_matches_total: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_item_reg.lit == (out_item_reg.total_duty != 16'd0)))
        else $error("lit flag disagrees with total duty");

    a_total_within_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
            (out_item_reg.total_duty <= full_duty(duty_bits_reg, MAX_DUTY_BITS)))
        else $error("total duty exceeds full scale");

    a_done_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        (eng_done && res_ready) |=> (out_valid_reg && !busy_reg))
        else $error("finished item not handed to output register");

endmodule

FILE: hdl/fdpm_mul.sv
// Shared 16x16 multiplier with a registered product.
// Depends on nothing; driven by fdpm_engine.
module fdpm_mul
(
    input  logic        clk,
    input  logic        en,
    input  logic [15:0] a,
    input  logic [15:0] b,
    output logic [31:0] prod
);

    logic [31:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= 32'(a) * 32'(b);
        end
    end

    assign prod = prod_reg;

endmodule

FILE: hdl/fdpm_engine.sv
// Sequencer for the duty computation: gamma or quadratic curve, constant division by
// folding, and warm/cool split, all through one shared multiplier. Uses fdpm_pkg, fdpm_mul.
module fdpm_engine
#(
    parameter int MAX_DUTY_BITS = fdpm_pkg::MAX_DUTY_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  fdpm_pkg::job_t     job,
    input  logic               res_ready,
    output logic               done,
    output fdpm_pkg::out_item_t result
);

    import fdpm_pkg::*;

    eng_state_t  state_reg, state_next;
    div_kind_t   div_reg, div_next;
    logic [31:0] rem_reg, rem_next;
    logic [15:0] q_reg, q_next;
    logic [15:0] total_reg, total_next;
    logic [15:0] warm_reg, warm_next;

    logic        mul_en;
    logic [15:0] mul_a;
    logic [15:0] mul_b;
    logic [31:0] mul_prod;

    logic [15:0] full;
    logic [15:0] fold_t;
    logic [31:0] fold_low;
    logic [15:0] fold_k;
    logic [31:0] fold_d;
    logic [31:0] fold_bias;
    logic [15:0] q_fix;
    logic [15:0] cool;

    fdpm_mul u_mul
    (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_prod)
    );

    assign full = full_duty(job.duty_bits, MAX_DUTY_BITS);

    always_comb
    begin
        case (div_reg)
            DIV_PCT:
            begin
                fold_t    = rem_reg[31:16];
                fold_low  = {16'd0, rem_reg[15:0]};
                fold_k    = DIV_PCT_K;
                fold_d    = DIV_PCT_D;
                fold_bias = DIV_PCT_BIAS;
            end
            DIV_WARM:
            begin
                fold_t    = rem_reg[22:7];
                fold_low  = {25'd0, rem_reg[6:0]};
                fold_k    = DIV_WARM_K;
                fold_d    = DIV_WARM_D;
                fold_bias = DIV_WARM_BIAS;
            end
            default:
            begin
                fold_t    = rem_reg[31:16];
                fold_low  = {16'd0, rem_reg[15:0]};
                fold_k    = DIV_LVL_K;
                fold_d    = DIV_LVL_D;
                fold_bias = DIV_LVL_BIAS;
            end
        endcase
    end

    assign q_fix = q_reg + 16'(rem_reg >= fold_d);

    always_comb
    begin
        state_next = state_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        total_next = total_reg;
        warm_next  = warm_reg;
        mul_en     = 1'b0;
        mul_a      = 16'd0;
        mul_b      = 16'd0;
        done       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (job.level_mode && (job.level != 8'd0))
                    begin
                        state_next = ST_SQUARE;
                    end
                    else if (!job.level_mode && (job.percent != 7'd0))
                    begin
                        state_next = ST_GAMMA;
                    end
                    else
                    begin
                        total_next = 16'd0;
                        state_next = ST_SPLIT;
                    end
                end
            end
            ST_SQUARE:
            begin
                mul_en     = 1'b1;
                mul_a      = 16'(job.level - 8'd1);
                mul_b      = 16'(job.level - 8'd1);
                div_next   = DIV_LVL;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                mul_en     = 1'b1;
                mul_a      = mul_prod[15:0];
                mul_b      = full - 16'd1;
                state_next = ST_LOAD;
            end
            ST_GAMMA:
            begin
                mul_en     = 1'b1;
                mul_a      = full;
                mul_b      = gamma_value(job.percent);
                div_next   = DIV_PCT;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                rem_next   = mul_prod + fold_bias;
                q_next     = 16'd0;
                state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                if (fold_t == 16'd0)
                begin
                    state_next = ST_FIX;
                end
                else
                begin
                    mul_en     = 1'b1;
                    mul_a      = fold_t;
                    mul_b      = fold_k;
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                rem_next   = fold_low + mul_prod;
                q_next     = q_reg + fold_t;
                state_next = ST_FOLD;
            end
            ST_FIX:
            begin
                case (div_reg)
                    DIV_PCT:
                    begin
                        total_next = (q_fix == 16'd0) ? 16'd1 : q_fix;
                        state_next = ST_SPLIT;
                    end
                    DIV_WARM:
                    begin
                        warm_next  = q_fix;
                        state_next = ST_DONE;
                    end
                    default:
                    begin
                        total_next = q_fix + 16'd1;
                        state_next = ST_SPLIT;
                    end
                endcase
            end
            ST_SPLIT:
            begin
                if (job.dual)
                begin
                    mul_en     = 1'b1;
                    mul_a      = total_reg;
                    mul_b      = 16'(job.share);
                    div_next   = DIV_WARM;
                    state_next = ST_LOAD;
                end
                else
                begin
                    warm_next  = 16'd0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                done = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg   <= div_next;
        rem_reg   <= rem_next;
        q_reg     <= q_next;
        total_reg <= total_next;
        warm_reg  <= warm_next;
    end

    assign cool = total_reg - warm_reg;

    always_comb
    begin
        result.cool_pin_duty = job.active_high ? cool : (full - cool);
        result.warm_pin_duty = job.dual ? (job.active_high ? warm_reg : (full - warm_reg))
                                        : 16'd0;
        result.warm_driven   = job.dual;
        result.total_duty    = total_reg;
        result.lit           = (total_reg != 16'd0);
    end

endmodule
